// ===== rtl/core/ubdc_pkg.sv =====
package ubdc_pkg;

   // Widths of the input fields and the result word.
   localparam int unsigned CLOCK_W = 27;
   localparam int unsigned BAUD_W  = 24;
   localparam int unsigned WORD_W  = 28;

   // 25 * clock fits in 32 bits; 4 * baud fits in 26 bits.
   localparam int unsigned DIVIDEND_W = 32;
   localparam int unsigned DEN_W      = 26;
   localparam int unsigned CELL_COUNT = DIVIDEND_W;

   // Floor division of a 32-bit value by 100: (x * RECIP_100) >> RECIP_SHIFT.
   localparam int unsigned RECIP_W     = 31;
   localparam logic [RECIP_W-1:0] RECIP_100 = 31'h51EB_851F;
   localparam int unsigned RECIP_SHIFT = 37;
   localparam int unsigned PROD_W      = DIVIDEND_W + RECIP_W;

   localparam int unsigned MANT_W = 24;
   localparam int unsigned REM_W  = 7;
   localparam logic [REM_W-1:0] HUNDRED = 7'd100;

   // Floor division by 100 of a value below 1700: (v * FRAC_RECIP) >> FRAC_SHIFT.
   localparam int unsigned FRAC_V_W    = 11;
   localparam logic [FRAC_V_W-1:0] FRAC_RECIP = 11'd1311;
   localparam int unsigned FRAC_SHIFT  = 17;
   localparam int unsigned FRAC_PROD_W = 2 * FRAC_V_W;
   localparam logic [FRAC_V_W-1:0] ROUND_HALF = 11'd50;

   localparam logic [WORD_W-1:0] WORD_ALL_ONES = '1;

   // One slot of the divider chain.
   typedef struct packed {
      logic                  valid;
      logic                  zero;
      logic                  over8;
      logic [DEN_W-1:0]      rem;
      logic [DIVIDEND_W-1:0] dq;
      logic [DEN_W-1:0]      den;
   } div_stage_type;

endpackage

// ===== rtl/core/uart_baud_divisor_calc_top.sv =====
// UART baud divisor calculator. Each req beat carries a peripheral clock in hertz, a
// baud rate and an oversample-by-8 flag; each rsp beat returns the baud-rate register
// word, mantissa in bits 27..4 and fraction in bits 3..0 (by 8: three fraction bits
// shifted up one, bit 0 zero). A rounding carry out of the fraction is dropped, not
// added to the mantissa. A zero baud rate returns all ones. The block is fully
// pipelined: it takes one beat per cycle while rsp is not stalled. A beat crosses
// one prep stage, a row of 32 restoring-divider cells that each settle one quotient
// bit, and three stages that split the quotient by 100 and round the fraction.
// While a result sits stalled at rsp, the whole pipeline holds and req_stall is raised.
module uart_baud_divisor_calc_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ubdc_pkg::CLOCK_W-1:0]    req_clock_hz,
   input  logic [ubdc_pkg::BAUD_W-1:0]     req_baud_rate,
   input  logic                            req_over8,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ubdc_pkg::WORD_W-1:0]     rsp_divisor_word
);

   logic                     advance;
   logic                     req_accept;
   ubdc_pkg::div_stage_type  prep_ff;
   ubdc_pkg::div_stage_type  prep_in;
   ubdc_pkg::div_stage_type  chain [0:ubdc_pkg::CELL_COUNT];
   logic [ubdc_pkg::DIVIDEND_W-1:0] clk_ext;

   // Advance everything unless a finished result is waiting on a stalled rsp.
   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   // Prep: dividend = 25 * clock, divisor = 2 or 4 times the baud rate.
   always_comb begin
      clk_ext       = {{(ubdc_pkg::DIVIDEND_W-ubdc_pkg::CLOCK_W){1'b0}}, req_clock_hz};
      prep_in.valid = req_accept;
      prep_in.zero  = (req_baud_rate == '0);
      prep_in.over8 = req_over8;
      prep_in.rem   = '0;
      prep_in.dq    = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
      prep_in.den   = req_over8 ? {1'b0, req_baud_rate, 1'b0} : {req_baud_rate, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   assign chain[0] = prep_ff;

   // One quotient bit per cell, most significant first.
   for (genvar i = 0; i < ubdc_pkg::CELL_COUNT; i++) begin : g_cell
      ubdc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   ubdc_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .quot_in    (chain[ubdc_pkg::CELL_COUNT]),
      .word_valid (rsp_valid),
      .word       (rsp_divisor_word)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with no waiting result");

   a_prep_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(prep_ff.valid))
      else $error("prep stage moved while frozen");

   a_zero_baud_word: assert property (@(posedge clock) disable iff (reset)
      (prep_ff.valid && prep_ff.zero) |-> (prep_ff.den == '0))
      else $error("zero baud flag disagrees with divisor");

endmodule

// ===== rtl/core/ubdc_div_cell.sv =====
module ubdc_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ubdc_pkg::div_stage_type stage_in,
   output ubdc_pkg::div_stage_type stage_out
);

   ubdc_pkg::div_stage_type stage_ff;
   ubdc_pkg::div_stage_type stage_in_next;
   logic [ubdc_pkg::DEN_W:0] shifted;
   logic [ubdc_pkg::DEN_W:0] diff;
   logic                     ge;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      shifted = {stage_in.rem, stage_in.dq[ubdc_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, stage_in.den};
      ge      = (shifted >= {1'b0, stage_in.den});
      stage_in_next       = stage_in;
      stage_in_next.rem   = ge ? diff[ubdc_pkg::DEN_W-1:0] : shifted[ubdc_pkg::DEN_W-1:0];
      stage_in_next.dq    = {stage_in.dq[ubdc_pkg::DIVIDEND_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (stage_ff.valid && !stage_ff.zero) |-> (stage_ff.rem < stage_ff.den))
      else $error("divider cell remainder not below divisor");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_ff.valid))
      else $error("divider cell moved while frozen");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (stage_ff.valid && stage_ff.zero) |-> (stage_ff.den == '0))
      else $error("zero flag disagrees with divisor");

endmodule

// ===== rtl/core/ubdc_finish.sv =====
module ubdc_finish (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ubdc_pkg::div_stage_type        quot_in,
   output logic                          word_valid,
   output logic [ubdc_pkg::WORD_W-1:0]   word
);

   // Stage B: quotient times reciprocal of 100.
   logic                            b_valid_ff;
   logic                            b_zero_ff;
   logic                            b_over8_ff;
   logic [ubdc_pkg::PROD_W-1:0]     b_prod_ff;
   logic [ubdc_pkg::REM_W-1:0]      b_qlow_ff;

   // Stage C: mantissa and remainder.
   logic                            c_valid_ff;
   logic                            c_zero_ff;
   logic                            c_over8_ff;
   logic [ubdc_pkg::MANT_W-1:0]     c_mant_ff;
   logic [ubdc_pkg::REM_W-1:0]      c_rem_ff;

   // Stage D: result register.
   logic                            d_valid_ff;
   logic                            d_over8_ff;
   logic [ubdc_pkg::WORD_W-1:0]     d_word_ff;

   logic [ubdc_pkg::PROD_W-1:0]     b_prod_in;
   logic [ubdc_pkg::MANT_W-1:0]     c_mant_in;
   logic [2*ubdc_pkg::REM_W-1:0]    c_low_prod;
   logic [ubdc_pkg::REM_W-1:0]      c_rem_in;
   logic [ubdc_pkg::FRAC_V_W-1:0]   frac_v;
   logic [ubdc_pkg::FRAC_PROD_W-1:0] frac_prod;
   logic [3:0]                      frac;
   logic [ubdc_pkg::WORD_W-1:0]     d_word_in;

   always_comb begin
      b_prod_in = quot_in.dq * ubdc_pkg::RECIP_100;
   end

   // Only the low bits of mantissa * 100 matter: the remainder is below 100.
   always_comb begin
      c_mant_in  = b_prod_ff[ubdc_pkg::RECIP_SHIFT +: ubdc_pkg::MANT_W];
      c_low_prod = c_mant_in[ubdc_pkg::REM_W-1:0] * ubdc_pkg::HUNDRED;
      c_rem_in   = b_qlow_ff - c_low_prod[ubdc_pkg::REM_W-1:0];
   end

   // Rounded fraction; the mask drops a carry out of the fraction field.
   always_comb begin
      if (c_over8_ff) begin
         frac_v = {1'b0, c_rem_ff, 3'b000} + ubdc_pkg::ROUND_HALF;
      end else begin
         frac_v = {c_rem_ff, 4'b0000} + ubdc_pkg::ROUND_HALF;
      end
      frac_prod = frac_v * ubdc_pkg::FRAC_RECIP;
      if (c_over8_ff) begin
         frac = {frac_prod[ubdc_pkg::FRAC_SHIFT +: 3], 1'b0};
      end else begin
         frac = frac_prod[ubdc_pkg::FRAC_SHIFT +: 4];
      end
      d_word_in = c_zero_ff ? ubdc_pkg::WORD_ALL_ONES : {c_mant_ff, frac};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= quot_in.valid;
         b_zero_ff  <= quot_in.zero;
         b_over8_ff <= quot_in.over8;
         b_prod_ff  <= b_prod_in;
         b_qlow_ff  <= quot_in.dq[ubdc_pkg::REM_W-1:0];
         c_valid_ff <= b_valid_ff;
         c_zero_ff  <= b_zero_ff;
         c_over8_ff <= b_over8_ff;
         c_mant_ff  <= c_mant_in;
         c_rem_ff   <= c_rem_in;
         d_valid_ff <= c_valid_ff;
         d_over8_ff <= c_over8_ff && !c_zero_ff;
         d_word_ff  <= d_word_in;
      end
   end

   assign word_valid = d_valid_ff;
   assign word       = d_word_ff;

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> (c_rem_ff < ubdc_pkg::HUNDRED))
      else $error("remainder by 100 out of range");

   a_over8_lsb: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && d_over8_ff) |-> (d_word_ff[0] == 1'b0))
      else $error("by-8 fraction has low bit set");

   a_word_hold: assert property (@(posedge clock) disable iff (reset)
      (!advance && d_valid_ff) |=> (d_valid_ff && $stable(d_word_ff)))
      else $error("result word changed while frozen");

endmodule
